// File: rtl/mfs_pkg.sv
package mfs_pkg;

  // Store geometry
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  // Operation codes
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // One stored entry
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   freq;
  } entry_t;

  // Compare request broadcast to every cell when an item is taken
  typedef struct packed {
    logic               sample;
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   freq;
  } bcast_t;

  // Per-cell update controls
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: rtl/mfs_cell.sv
module mfs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfs_pkg::bcast_t     bcast_i,
  input  mfs_pkg::cell_ctrl_t ctrl_i,
  input  mfs_pkg::entry_t     load_i,
  input  mfs_pkg::entry_t     upper_i,
  output mfs_pkg::entry_t     entry_o,
  output logic                hit_o
);

  logic                        valid_q;
  logic                        valid_d;
  logic [mfs_pkg::VALUE_W-1:0] value_q;
  logic [mfs_pkg::VALUE_W-1:0] value_d;
  logic [mfs_pkg::CNT_W-1:0]   freq_q;
  logic [mfs_pkg::CNT_W-1:0]   freq_d;
  logic                        hit_q;
  logic                        hit_d;

  // Next entry: a push loads here, a pop below or at this cell pulls the upper neighbour down
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    freq_d  = freq_q;
    if (ctrl_i.load) begin
      valid_d = 1'b1;
      value_d = load_i.value;
      freq_d  = load_i.freq;
    end else if (ctrl_i.shift) begin
      valid_d = upper_i.valid;
      value_d = upper_i.value;
      freq_d  = upper_i.freq;
    end
  end

  // Local match: same value for a push, top frequency for a pop
  always_comb begin
    hit_d = hit_q;
    if (bcast_i.sample) begin
      if (bcast_i.op == mfs_pkg::OP_PUSH) begin
        hit_d = valid_q && (value_q == bcast_i.value);
      end else begin
        hit_d = valid_q && (freq_q == bcast_i.freq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    freq_q  <= freq_d;
  end

  assign entry_o = '{valid: valid_q, value: value_q, freq: freq_q};
  assign hit_o   = hit_q;

endmodule

// File: rtl/max_frequency_stack.sv
// valid_o is registered from busy, which is registered when an item is taken; the
//   result is shown while valid_o is high.
// No new item is taken while busy is high; busy is high for the cycle in which the
//   cells' registered match flags are reduced and the chain is updated.
// The next item may be taken in the cycle its predecessor's result is shown.
// Reset (rst_ni, asynchronous, active low) empties the store; no result stalls.
module max_frequency_stack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]         status_o
);

  localparam int DEPTH = mfs_pkg::DEPTH;
  localparam int CNT_W = mfs_pkg::CNT_W;
  localparam int IDX_W = mfs_pkg::IDX_W;
  localparam int VW    = mfs_pkg::VALUE_W;

  logic                  busy_q;
  logic                  busy_d;
  mfs_pkg::op_e          op_q;
  logic [VW-1:0]         value_q;
  logic [CNT_W-1:0]      occ_q;
  logic [CNT_W-1:0]      occ_d;
  logic [CNT_W-1:0]      max_freq_q;
  logic [CNT_W-1:0]      max_freq_d;
  logic                  res_valid_q;
  mfs_pkg::status_e      res_status_q;
  mfs_pkg::status_e      res_status_d;
  logic [VW-1:0]         res_value_q;
  logic [VW-1:0]         res_value_d;

  logic                  accept;
  mfs_pkg::bcast_t       bcast;
  mfs_pkg::entry_t       load_entry;
  mfs_pkg::entry_t       entries [DEPTH];
  mfs_pkg::cell_ctrl_t   ctrl    [DEPTH];
  logic [DEPTH-1:0]      hits;
  logic [DEPTH-1:0]      hits_rev;
  logic [DEPTH-1:0]      iso_rev;
  logic [DEPTH-1:0]      win;
  logic [DEPTH-1:0]      below;
  logic [VW-1:0]         sel_value;
  logic [CNT_W-1:0]      sel_freq;
  logic [CNT_W-1:0]      new_freq;
  logic                  other_hit;
  logic                  full;
  logic                  empty;
  logic                  do_push;
  logic                  do_pop;

  assign accept = start && !busy_q;

  // Broadcast compare request to the cells as the item is taken
  always_comb begin
    bcast.sample = accept;
    bcast.op     = mfs_pkg::op_e'(op_i);
    bcast.value  = $unsigned(value_i);
    bcast.freq   = max_freq_q;
  end

  // Chain of cells, each fed by its upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mfs_pkg::entry_t upper;
    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = entries[i+1];
    end
    assign ctrl[i].load  = do_push && (occ_q[IDX_W-1:0] == IDX_W'(i));
    assign ctrl[i].shift = do_pop && !below[i];
    mfs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .ctrl_i  (ctrl[i]),
      .load_i  (load_entry),
      .upper_i (upper),
      .entry_o (entries[i]),
      .hit_o   (hits[i])
    );
  end

  // Youngest flagged cell: isolate the highest set bit
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hits_rev[i] = hits[DEPTH-1-i];
    end
    iso_rev = hits_rev & (~hits_rev + DEPTH'(1));
    for (int i = 0; i < DEPTH; i++) begin
      win[i] = iso_rev[DEPTH-1-i];
    end
    below     = win - DEPTH'(1);
    other_hit = |(hits & ~win);
  end

  // Read out the selected cell
  always_comb begin
    sel_value = '0;
    sel_freq  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (win[i]) begin
        sel_value = sel_value | entries[i].value;
        sel_freq  = sel_freq | entries[i].freq;
      end
    end
  end

  // Commit decision and next state
  always_comb begin
    full     = (occ_q == CNT_W'(DEPTH));
    empty    = (occ_q == '0);
    do_push  = busy_q && (op_q == mfs_pkg::OP_PUSH) && !full;
    do_pop   = busy_q && (op_q == mfs_pkg::OP_POP) && !empty;
    new_freq = sel_freq + CNT_W'(1);

    load_entry.valid = 1'b1;
    load_entry.value = value_q;
    load_entry.freq  = new_freq;

    busy_d       = accept;
    occ_d        = occ_q;
    max_freq_d   = max_freq_q;
    res_value_d  = '0;
    res_status_d = mfs_pkg::ST_PUSHED;

    if (busy_q) begin
      if (op_q == mfs_pkg::OP_PUSH) begin
        if (full) begin
          res_status_d = mfs_pkg::ST_FULL;
        end else begin
          occ_d = occ_q + CNT_W'(1);
          if (new_freq > max_freq_q) begin
            max_freq_d = new_freq;
          end
        end
      end else begin
        if (empty) begin
          res_status_d = mfs_pkg::ST_EMPTY;
        end else begin
          res_status_d = mfs_pkg::ST_POPPED;
          res_value_d  = sel_value;
          occ_d        = occ_q - CNT_W'(1);
          if (!other_hit) begin
            max_freq_d = max_freq_q - CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      occ_q       <= '0;
      max_freq_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      occ_q       <= occ_d;
      max_freq_q  <= max_freq_d;
      res_valid_q <= busy_q;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= mfs_pkg::op_e'(op_i);
      value_q <= $unsigned(value_i);
    end
    if (busy_q) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
    end
  end

  assign busy           = busy_q;
  assign valid_o        = res_valid_q;
  assign popped_value_o = $signed(res_value_q);
  assign status_o       = res_status_q;

`ifndef SYNTH
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(busy_q))
    else $error("result strobe without a processed item");

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("busy held for more than one cycle");

  a_pop_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> $onehot(win))
    else $error("pop of a non-empty store found no single winner");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_push_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |-> (new_freq <= occ_q + CNT_W'(1)) && (new_freq != '0))
    else $error("push frequency out of range");
`endif

endmodule

// File: test/max_frequency_stack_checker.sv
module max_frequency_stack_checker
  import mfs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic                      op_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      valid_i,
  input  logic signed [VALUE_W-1:0] popped_value_i,
  input  logic [1:0]                status_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [VALUE_W-1:0] popped;
    status_e                   status;
  } stack_result_t;

  // Shadow copy of the store, packed oldest first
  logic signed [VALUE_W-1:0] shadow_value [DEPTH];
  logic [CNT_W-1:0]          shadow_freq  [DEPTH];
  int                        shadow_fill;

  stack_result_t awaited_results [$];
  stack_result_t oldest;
  int            mismatches;

  // Apply one item to the shadow store and return the result it gives
  function automatic stack_result_t step_stack(op_e op, logic signed [VALUE_W-1:0] v);
    stack_result_t r;
    int            best;
    int            same_count;
    int            i;
    r.popped = '0;
    if (op == OP_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        same_count = 0;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_value[i] == v) same_count++;
        end
        shadow_value[shadow_fill] = v;
        shadow_freq[shadow_fill]  = CNT_W'(same_count + 1);
        shadow_fill++;
        r.status = ST_PUSHED;
      end
    end else if (shadow_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // >= on an ascending scan: youngest wins a tie
      best = 0;
      for (i = 1; i < shadow_fill; i++) begin
        if (shadow_freq[i] >= shadow_freq[best]) best = i;
      end
      r.popped = shadow_value[best];
      for (i = best; i < shadow_fill - 1; i++) begin
        shadow_value[i] = shadow_value[i + 1];
        shadow_freq[i]  = shadow_freq[i + 1];
      end
      shadow_fill--;
      r.status = ST_POPPED;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compare results against the oldest awaited one, then queue the new item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      mismatches  = 0;
      awaited_results.delete();
    end else begin
      if (valid_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited, status %0d value %0d",
                                    status_i, popped_value_i));
        end else begin
          oldest = awaited_results.pop_front();
          if (status_i !== oldest.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      status_i, oldest.status));
          if (popped_value_i !== oldest.popped)
            report_mismatch($sformatf("popped_value got %0d expected %0d",
                                      popped_value_i, oldest.popped));
        end
      end
      if (start_i && !busy_i)
        awaited_results.push_back(step_stack(op_e'(op_i), value_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_results.size();
  end

endmodule

// File: test/max_frequency_stack_tb.sv
module max_frequency_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfs_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASE_LEN    = 130;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;
  localparam int IDLE_PCT     = 34;

  logic                      clk_i   = 1'b0;
  logic                      rst_ni  = 1'b0;
  logic                      start   = 1'b0;
  logic                      op_i    = OP_PUSH;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      busy;
  logic                      valid_o;
  logic signed [VALUE_W-1:0] popped_value_o;
  logic [1:0]                status_o;
  int                        fail_count;
  int                        pending_count;
  int                        cycle_count = 0;

  // Push bias per phase: fill, drain, then mixed levels
  int push_bias [15] = '{100, 0, 80, 50, 95, 5, 65, 35, 50, 90, 10, 60, 50, 75, 25};
  logic signed [VALUE_W-1:0] pool [6];
  int                        pool_size;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  max_frequency_stack u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .value_i        (value_i),
    .valid_o        (valid_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o)
  );

  max_frequency_stack_checker u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .op_i           (op_i),
    .value_i        (value_i),
    .valid_i        (valid_o),
    .popped_value_i (popped_value_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  // Present one item, wait for it to be taken, then maybe idle or drain
  task automatic run_item(op_e op, logic signed [VALUE_W-1:0] v, bit calm, bit drain);
    int gap;
    gap = 0;
    start   <= 1'b1;
    op_i    <= op;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain) begin
        @(posedge clk_i);
        while (pending_count != 0) @(posedge clk_i);
      end
    end
  endtask

  // Mostly a small pool so frequencies build up; some fully random values
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 85) return pool[$urandom_range(pool_size - 1)];
    return $urandom;
  endfunction

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int  n;
    int  phase;
    bit  calm;
    op_e op;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, extremes, frequency order and ties, drain to empty
    run_item(OP_POP,  $urandom, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh8000_0000, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh7fff_ffff, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh8000_0000, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh0000_0000, 1'b0, 1'b0);
    run_item(OP_PUSH, -32'sd1, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh7fff_ffff, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh8000_0000, 1'b0, 1'b1);
    run_item(OP_POP,  $urandom, 1'b1, 1'b0);
    run_item(OP_POP,  $urandom, 1'b1, 1'b0);
    run_item(OP_POP,  $urandom, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'sh5555_5555, 1'b0, 1'b0);
    run_item(OP_PUSH, 32'shaaaa_aaaa, 1'b0, 1'b0);
    repeat (6) run_item(OP_POP, $urandom, 1'b0, 1'b0);
    run_item(OP_POP,  $urandom, 1'b0, 1'b1);

    // Random phases, each with its own value pool and push bias
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n / PHASE_LEN;
      if (n % PHASE_LEN == 0) begin
        pool_size = $urandom_range(1, 6);
        foreach (pool[k]) pool[k] = $urandom;
        if ($urandom_range(3) == 0) pool[0] = 32'sh8000_0000;
        if ($urandom_range(3) == 0) pool[1] = 32'sh7fff_ffff;
      end
      op   = ($urandom_range(99) < push_bias[phase % 15]) ? OP_PUSH : OP_POP;
      calm = (n >= 900 && n < 1200);
      run_item(op, (op == OP_PUSH) ? pick_value() : $urandom, calm, (n % 400 == 399));
    end

    // Let every result arrive, then a short tail
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mfs_pkg.sv
rtl/mfs_cell.sv
rtl/max_frequency_stack.sv
test/max_frequency_stack_checker.sv
test/max_frequency_stack_tb.sv
